// ===== hw/rtl/hsvrgb_pkg.sv =====
// hsvrgb_pkg: transaction types and fixed constants of the HSV to RGB converter.
// Used by hsvrgb_round and hsv_to_rgb_converter_core; depends on nothing.
`timescale 1ns / 1ps

package hsvrgb_pkg;

   // Width of each output colour channel.
   localparam int CHANNEL_BITS = 8;

   localparam int DEG_PER_SECTOR = 60;
   localparam int HUE_RANGE      = 360;
   localparam int FRAC_FULL      = 255;

   // Per-channel term T, where the channel numerator is V * T over DENOM.
   localparam int T_W    = 14;
   localparam int T_FULL = DEG_PER_SECTOR * FRAC_FULL;

   // Channel numerator and its denominator 255 * 255 * 60.
   localparam int NUM_W  = 22;
   localparam int DENOM  = FRAC_FULL * FRAC_FULL * DEG_PER_SECTOR;
   localparam int DENOM2 = 2 * DENOM;

   // Rounding dividend 2*N*Q + DENOM stays below DENOM2 * 2^CHANNEL_BITS.
   localparam int ACC_W = 23 + CHANNEL_BITS;

   // Rounded-up reciprocal of DENOM2; the product with any ACC_W-bit dividend,
   // shifted down by RECIP_SHIFT, gives the exact floor quotient.
   localparam int              DENOM2_W    = $clog2(DENOM2);
   localparam int              RECIP_SHIFT = ACC_W + DENOM2_W;
   localparam int              RECIP_W     = ACC_W + 1;
   localparam longint unsigned RECIP       =
      ((64'd1 << RECIP_SHIFT) + 64'(DENOM2) - 64'd1) / 64'(DENOM2);

   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rsp_type;

endpackage

// ===== hw/rtl/hsvrgb_round.sv =====
// hsvrgb_round: one-stage rounding scale of a channel by reciprocal multiplication.
// Depends on hsvrgb_pkg for the channel width, dividend width and reciprocal.
`timescale 1ns / 1ps

module hsvrgb_round (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic [hsvrgb_pkg::ACC_W-1:0]         acc,
   output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  level
);

   localparam int CB     = hsvrgb_pkg::CHANNEL_BITS;
   localparam int ACC_W  = hsvrgb_pkg::ACC_W;
   localparam int RCP_W  = hsvrgb_pkg::RECIP_W;
   localparam int PROD_W = ACC_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(hsvrgb_pkg::RECIP);

   logic [PROD_W-1:0] prod;
   logic [CB-1:0]     level_ff;

   // Floor of acc / DENOM2: multiply by the reciprocal, keep the bits above the shift.
   assign prod = PROD_W'(acc) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= prod[hsvrgb_pkg::RECIP_SHIFT +: CB];
      end
   end

   assign level = level_ff;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_core.sv =====
// hsv_to_rgb_converter_core: top level of the HSV to RGB colour converter.
// Depends on hsvrgb_pkg and instantiates hsvrgb_round once per channel.
`timescale 1ns / 1ps

// The converter takes one HSV transaction per clock while not stalled and
// returns one RGB transaction for each, in order. Four front stages
// split the hue into sector and offset, build the per-channel term, multiply
// by brightness and form the rounding dividend, then a fifth stage scales
// each channel by multiplying with the reciprocal of the rounding divisor.
// Every stage carries its own valid bit and loads whenever the stage after
// it can take its contents, so a stalled result holds only the stages
// behind it that are full and new transactions keep filling any bubbles.
// Hues of 360 to 511 wrap round the colour circle by 360; channel values
// halfway between two codes round up.

module hsv_to_rgb_converter_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hsvrgb_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hsvrgb_pkg::rsp_type rsp_payload
);

   localparam int CB    = hsvrgb_pkg::CHANNEL_BITS;
   localparam int T_W   = hsvrgb_pkg::T_W;
   localparam int NUM_W = hsvrgb_pkg::NUM_W;
   localparam int ACC_W = hsvrgb_pkg::ACC_W;
   localparam int FRONT = 4;
   localparam int NST   = FRONT + 1;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   localparam logic [8:0]     SPAN      = 9'(hsvrgb_pkg::DEG_PER_SECTOR);
   localparam logic [8:0]     HUE_WRAP  = 9'(hsvrgb_pkg::HUE_RANGE);
   localparam logic [5:0]     SPAN_OFF  = 6'(hsvrgb_pkg::DEG_PER_SECTOR);
   localparam logic [T_W-1:0] T_FULL    = T_W'(hsvrgb_pkg::T_FULL);
   localparam logic [T_W-1:0] SPAN_T    = T_W'(hsvrgb_pkg::DEG_PER_SECTOR);
   localparam logic [ACC_W-1:0] DENOM_A = ACC_W'(hsvrgb_pkg::DENOM);

   // Sectors of the colour circle, named by the hues at their ends.
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   // Pipeline control: one valid bit per stage, advance when the stage is
   // empty or the next one moves.
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST-1:0] adv;

   always_comb begin
      adv[NST-1] = !valid_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NST; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NST-1];

   // Stage 1: wrap the hue, split it into sector and offset in the sector.
   sector_type sector_in;
   sector_type sector_ff;
   logic [8:0] hue_wrap;
   logic [8:0] base;
   logic [8:0] off_wide;
   logic [5:0] off_ff;
   logic [7:0] sat1_ff;
   logic [7:0] val1_ff;

   always_comb begin
      hue_wrap = (req_payload.hue >= HUE_WRAP) ? req_payload.hue - HUE_WRAP
                                               : req_payload.hue;
      if (hue_wrap < SPAN) begin
         sector_in = SECTOR_RED_YELLOW;
         base      = '0;
      end else if (hue_wrap < 9'(2 * SPAN)) begin
         sector_in = SECTOR_YELLOW_GREEN;
         base      = SPAN;
      end else if (hue_wrap < 9'(3 * SPAN)) begin
         sector_in = SECTOR_GREEN_CYAN;
         base      = 9'(2 * SPAN);
      end else if (hue_wrap < 9'(4 * SPAN)) begin
         sector_in = SECTOR_CYAN_BLUE;
         base      = 9'(3 * SPAN);
      end else if (hue_wrap < 9'(5 * SPAN)) begin
         sector_in = SECTOR_BLUE_MAGENTA;
         base      = 9'(4 * SPAN);
      end else begin
         sector_in = SECTOR_MAGENTA_RED;
         base      = 9'(5 * SPAN);
      end
      off_wide = hue_wrap - base;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sector_ff <= sector_in;
         off_ff    <= off_wide[5:0];
         sat1_ff   <= req_payload.saturation;
         val1_ff   <= req_payload.brightness;
      end
   end

   // Stage 2: per-channel term T. Chroma takes T_FULL, the zero component
   // takes T_FULL - 60*S, and the second component adds S times its slope.
   logic             odd;
   logic [5:0]       slope;
   logic [T_W-1:0]   sat_x;
   logic [T_W-1:0]   sat_span;
   logic [T_W-1:0]   t_zero;
   logic [T_W-1:0]   t_x;
   logic [T_W-1:0]   t_in  [3];
   logic [T_W-1:0]   t_ff  [3];
   logic [7:0]       val2_ff;

   always_comb begin
      odd      = (sector_ff == SECTOR_YELLOW_GREEN) || (sector_ff == SECTOR_CYAN_BLUE)
                 || (sector_ff == SECTOR_MAGENTA_RED);
      slope    = odd ? SPAN_OFF - off_ff : off_ff;
      sat_x    = T_W'(sat1_ff) * T_W'(slope);
      sat_span = T_W'(sat1_ff) * SPAN_T;
      t_zero   = T_FULL - sat_span;
      t_x      = t_zero + sat_x;
      case (sector_ff)
         SECTOR_RED_YELLOW: begin
            t_in[CH_RED] = T_FULL; t_in[CH_GREEN] = t_x;    t_in[CH_BLUE] = t_zero;
         end
         SECTOR_YELLOW_GREEN: begin
            t_in[CH_RED] = t_x;    t_in[CH_GREEN] = T_FULL; t_in[CH_BLUE] = t_zero;
         end
         SECTOR_GREEN_CYAN: begin
            t_in[CH_RED] = t_zero; t_in[CH_GREEN] = T_FULL; t_in[CH_BLUE] = t_x;
         end
         SECTOR_CYAN_BLUE: begin
            t_in[CH_RED] = t_zero; t_in[CH_GREEN] = t_x;    t_in[CH_BLUE] = T_FULL;
         end
         SECTOR_BLUE_MAGENTA: begin
            t_in[CH_RED] = t_x;    t_in[CH_GREEN] = t_zero; t_in[CH_BLUE] = T_FULL;
         end
         default: begin
            t_in[CH_RED] = T_FULL; t_in[CH_GREEN] = t_zero; t_in[CH_BLUE] = t_x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t_ff    <= t_in;
         val2_ff <= val1_ff;
      end
   end

   // Stage 3: channel numerator N = V * T.
   logic [NUM_W-1:0] n_ff [3];

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int c = 0; c < 3; c++) begin
            n_ff[c] <= NUM_W'(val2_ff) * NUM_W'(t_ff[c]);
         end
      end
   end

   // Stage 4: rounding dividend 2*N*Q + DENOM, with N*Q as a shift and subtract.
   logic [ACC_W-1:0] acc_ff [3];

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= (((ACC_W'(n_ff[c]) << CB) - ACC_W'(n_ff[c])) << 1) + DENOM_A;
         end
      end
   end

   // Stage 5: divide by 2*DENOM through a multiply by its reciprocal.
   logic [CB-1:0] level [3];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      hsvrgb_round u_round (
         .clock (clock),
         .load  (adv[FRONT]),
         .acc   (acc_ff[c]),
         .level (level[c])
      );
   end

   assign rsp_payload.red   = level[CH_RED];
   assign rsp_payload.green = level[CH_GREEN];
   assign rsp_payload.blue  = level[CH_BLUE];

   // Reset empties the whole pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input is held back only when the first stage is occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[0])
      else $error("input stalled with an empty first stage");

   // The sector split leaves an offset below one sector.
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (off_ff < SPAN_OFF))
      else $error("hue offset outside its sector");

   // At least one channel carries the chroma term in every sector.
   a_chroma_routed: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (t_ff[CH_RED] == T_FULL || t_ff[CH_GREEN] == T_FULL
                       || t_ff[CH_BLUE] == T_FULL))
      else $error("no channel carries chroma");

endmodule
